@@ hw/rtl/soa_pkg.sv @@
`timescale 1ns / 1ps

package soa_pkg;

    localparam int NUM_PAGES     = 16;
    localparam int MAX_SLOTS     = 256;
    localparam int PG_W          = $clog2(NUM_PAGES);
    localparam int SLOT_W        = $clog2(MAX_SLOTS);
    localparam int H_W           = PG_W + SLOT_W + 1;
    localparam int P_W           = PG_W + 1;
    localparam int OBJ_W         = SLOT_W + 1;
    localparam int CNT5_W        = 5;
    localparam int DEF_CPU_LIMIT = 16;
    localparam int DEF_CPU_BATCH = 8;

    localparam logic [H_W-1:0]   HNIL    = H_W'(NUM_PAGES * MAX_SLOTS);
    localparam logic [P_W-1:0]   PNIL    = P_W'(NUM_PAGES);
    localparam logic [OBJ_W-1:0] OBJ_RST = OBJ_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_OOM = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic        op;
        logic [11:0] object_handle;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [11:0] handle_out;
        logic [4:0]  partial_pages;
        logic [4:0]  slabs_used;
    } t_rsp;

    typedef enum logic [4:0] {
        C_NOP, C_ACCEPT, C_RD_CPU, C_POP, C_INC, C_LD_CPU_PAGE, C_ACQ, C_TAKE_PART,
        C_PREMOVE, C_PADD, C_NEW_SLAB, C_THREAD, C_BATCH_RD, C_BATCH_WR, C_DEC,
        C_PUSH, C_FL_RD, C_FL_POP, C_FL_WR, C_CPU_CHK, C_FREE_LINK, C_RELEASE,
        C_SET_OOM, C_SET_BAD, C_EMIT
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_RD_CPU, S_POP, S_INC, S_PREM_INC, S_LD_CPU_PAGE, S_ACQ,
        S_TAKE_PART, S_PREM_ACQ, S_NEW_SLAB, S_THREAD, S_BATCH_RD, S_BATCH_WR, S_OOM,
        S_FREE_BR, S_PUSH, S_FL_RD, S_FL_POP, S_FL_WR, S_PADD_FL, S_FREE_LINK,
        S_PREM_REL, S_RELEASE, S_PADD_FR, S_EMIT
    } t_state;

    typedef struct packed {
        logic op;
        logic cpu_empty;
        logic pg_valid;
        logic fh_nil;
        logic inc_full;
        logic part_empty;
        logic slab_avail;
        logic bad_free;
        logic is_cpu_page;
        logic batch_more;
        logic thread_last;
        logic flush_more;
        logic flush_add;
        logic zero;
        logic part_ok;
        logic out_busy;
    } t_dp_st;

endpackage

@@ hw/rtl/slab_object_allocator.sv @@
`timescale 1ns / 1ps
// Slab object allocator for one object cache over a pool of 16 pages.
// Request channel: i_in_valid with i_in (op, object_handle); the block raises
// o_in_stall whenever it is busy and takes a request only when idle.
// Result channel: o_out_valid with o_out (status, handle_out, partial page
// count, slab count); one result per request. While i_out_stall is high the
// result is held in the output register, and the next request may still be
// taken and worked on until its own result is ready.
// The slot count for new slabs is written through i_cfg_we / i_cfg_data.
// An allocation pops the per-CPU stack; an empty stack is first refilled with
// up to CPU_BATCH objects from the CPU page, a partial page or a fresh slab
// threaded one slot at a time. A free on the CPU page pushes onto the stack and
// flushes objects back while it holds more than CPU_LIMIT. A new request can be
// taken in the cycle after the result is loaded. The link memory takes one
// access per cycle.
// Reset is synchronous and active low; the page tables come up empty at once,
// and no clearing pass is needed before the first request.
module slab_object_allocator import soa_pkg::*; #(
    parameter int CPU_LIMIT = DEF_CPU_LIMIT,
    parameter int CPU_BATCH = DEF_CPU_BATCH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_rsp             o_out,
    input  logic             i_cfg_we,
    input  logic [OBJ_W-1:0] i_cfg_data
);

    t_cmd   cmd;
    t_dp_st st;

    soa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    soa_datapath #(
        .CPU_LIMIT (CPU_LIMIT),
        .CPU_BATCH (CPU_BATCH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ hw/rtl/soa_ctrl.sv @@
`timescale 1ns / 1ps

module soa_ctrl import soa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_dp_st i_st,
    output logic   o_in_stall,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = C_NOP;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = C_ACCEPT;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_st.op == OP_ALLOC) begin
                    n_state = i_st.cpu_empty ? S_LD_CPU_PAGE : S_RD_CPU;
                end else if (i_st.bad_free) begin
                    o_cmd   = C_SET_BAD;
                    n_state = S_EMIT;
                end else begin
                    o_cmd   = C_DEC;
                    n_state = S_FREE_BR;
                end
            end
            S_RD_CPU: begin
                o_cmd   = C_RD_CPU;
                n_state = S_POP;
            end
            S_POP: begin
                o_cmd   = C_POP;
                n_state = S_INC;
            end
            S_INC: begin
                o_cmd   = C_INC;
                n_state = i_st.inc_full ? S_PREM_INC : S_EMIT;
            end
            S_PREM_INC: begin
                o_cmd   = C_PREMOVE;
                n_state = S_EMIT;
            end
            S_LD_CPU_PAGE: begin
                o_cmd   = C_LD_CPU_PAGE;
                n_state = S_ACQ;
            end
            S_ACQ: begin
                o_cmd = C_ACQ;
                if (i_st.pg_valid && !i_st.fh_nil) begin
                    n_state = S_BATCH_RD;
                end else if (!i_st.part_empty) begin
                    n_state = S_TAKE_PART;
                end else if (i_st.slab_avail) begin
                    n_state = S_NEW_SLAB;
                end else begin
                    n_state = S_OOM;
                end
            end
            S_TAKE_PART: begin
                o_cmd   = C_TAKE_PART;
                n_state = S_PREM_ACQ;
            end
            S_PREM_ACQ: begin
                o_cmd   = C_PREMOVE;
                n_state = S_BATCH_RD;
            end
            S_NEW_SLAB: begin
                o_cmd   = C_NEW_SLAB;
                n_state = S_THREAD;
            end
            S_THREAD: begin
                o_cmd = C_THREAD;
                if (i_st.thread_last) begin
                    n_state = S_BATCH_RD;
                end
            end
            S_BATCH_RD: begin
                if (i_st.batch_more) begin
                    o_cmd   = C_BATCH_RD;
                    n_state = S_BATCH_WR;
                end else begin
                    n_state = i_st.cpu_empty ? S_OOM : S_RD_CPU;
                end
            end
            S_BATCH_WR: begin
                o_cmd   = C_BATCH_WR;
                n_state = S_BATCH_RD;
            end
            S_OOM: begin
                o_cmd   = C_SET_OOM;
                n_state = S_EMIT;
            end
            S_FREE_BR: begin
                n_state = i_st.is_cpu_page ? S_PUSH : S_FREE_LINK;
            end
            S_PUSH: begin
                o_cmd   = C_PUSH;
                n_state = S_FL_RD;
            end
            S_FL_RD: begin
                if (i_st.flush_more) begin
                    o_cmd   = C_FL_RD;
                    n_state = S_FL_POP;
                end else begin
                    o_cmd   = C_CPU_CHK;
                    n_state = S_EMIT;
                end
            end
            S_FL_POP: begin
                o_cmd   = C_FL_POP;
                n_state = S_FL_WR;
            end
            S_FL_WR: begin
                o_cmd   = C_FL_WR;
                n_state = i_st.flush_add ? S_PADD_FL : S_FL_RD;
            end
            S_PADD_FL: begin
                o_cmd   = C_PADD;
                n_state = S_FL_RD;
            end
            S_FREE_LINK: begin
                o_cmd = C_FREE_LINK;
                if (i_st.zero) begin
                    n_state = S_PREM_REL;
                end else if (i_st.part_ok) begin
                    n_state = S_PADD_FR;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_PREM_REL: begin
                o_cmd   = C_PREMOVE;
                n_state = S_RELEASE;
            end
            S_RELEASE: begin
                o_cmd   = C_RELEASE;
                n_state = S_EMIT;
            end
            S_PADD_FR: begin
                o_cmd   = C_PADD;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_st.out_busy) begin
                    o_cmd   = C_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/soa_datapath.sv @@
`timescale 1ns / 1ps

module soa_datapath import soa_pkg::*; #(
    parameter int CPU_LIMIT = DEF_CPU_LIMIT,
    parameter int CPU_BATCH = DEF_CPU_BATCH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [OBJ_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    output t_dp_st           o_st,
    output logic             o_out_valid,
    output t_rsp             o_out
);

    localparam int CNT_MAX = (CPU_LIMIT + 1 > CPU_BATCH) ? CPU_LIMIT + 1 : CPU_BATCH;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    logic [OBJ_W-1:0]  r_cfg;
    logic [H_W-1:0]    r_link [NUM_PAGES*MAX_SLOTS];
    logic [H_W-1:0]    r_rdata;
    logic [H_W-1:0]    r_cpu_head;
    logic [CNT_W-1:0]  r_cpu_cnt;
    logic [P_W-1:0]    r_cpu_page;
    logic [P_W-1:0]    r_phead;
    logic [CNT5_W-1:0] r_ptotal;
    logic [CNT5_W-1:0] r_stotal;
    logic [H_W-1:0]    r_fhead [NUM_PAGES];
    logic [OBJ_W-1:0]  r_inuse [NUM_PAGES];
    logic [OBJ_W-1:0]  r_objs  [NUM_PAGES];
    logic [P_W-1:0]    r_pprev [NUM_PAGES];
    logic [P_W-1:0]    r_pnext [NUM_PAGES];
    logic [NUM_PAGES-1:0] r_slab;
    logic [NUM_PAGES-1:0] r_onp;
    logic              r_op;
    logic [H_W-1:0]    r_h;
    logic [P_W-1:0]    r_pg;
    logic [OBJ_W-1:0]  r_cnt;
    logic [OBJ_W-1:0]  r_n;
    logic              r_zero;
    t_status           r_stat;
    logic [11:0]       r_hout;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [PG_W-1:0]   ix;
    logic [H_W-1:0]    fh;
    logic [OBJ_W-1:0]  inu;
    logic [OBJ_W-1:0]  obj;
    logic [P_W-1:0]    pr;
    logic [P_W-1:0]    nx;
    logic              onp;
    logic [PG_W-1:0]   free_pg;
    logic [OBJ_W-1:0]  n_clamp;
    logic              mem_we;
    logic [H_W-2:0]    mem_waddr;
    logic [H_W-1:0]    mem_wdata;
    logic              mem_re;
    logic [H_W-2:0]    mem_raddr;

    assign ix  = r_pg[PG_W-1:0];
    assign fh  = r_fhead[ix];
    assign inu = r_inuse[ix];
    assign obj = r_objs[ix];
    assign pr  = r_pprev[ix];
    assign nx  = r_pnext[ix];
    assign onp = r_onp[ix];

    always_comb begin
        free_pg = '0;
        for (int p = NUM_PAGES - 1; p >= 0; p--) begin
            if (!r_slab[p]) begin
                free_pg = PG_W'(p);
            end
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            n_clamp = OBJ_W'(1);
        end else if (r_cfg > OBJ_RST) begin
            n_clamp = OBJ_RST;
        end else begin
            n_clamp = r_cfg;
        end
    end

    always_comb begin
        o_st.op          = r_op;
        o_st.cpu_empty   = (r_cpu_head == HNIL);
        o_st.pg_valid    = !r_pg[PG_W];
        o_st.fh_nil      = (fh == HNIL);
        o_st.inc_full    = ((inu + OBJ_W'(1)) == obj);
        o_st.part_empty  = r_phead[PG_W];
        o_st.slab_avail  = !(&r_slab);
        o_st.bad_free    = !r_slab[ix] || ({1'b0, r_h[SLOT_W-1:0]} >= obj) || (inu == '0);
        o_st.is_cpu_page = (r_pg == r_cpu_page);
        o_st.batch_more  = (r_cnt < OBJ_W'(CPU_BATCH)) && (fh != HNIL);
        o_st.thread_last = (r_cnt == r_n - OBJ_W'(1));
        o_st.flush_more  = (r_cpu_head != HNIL) && (r_cpu_cnt > CNT_W'(CPU_LIMIT));
        o_st.flush_add   = (r_pg != r_cpu_page) && (inu < obj);
        o_st.zero        = (inu == '0);
        o_st.part_ok     = (inu < obj);
        o_st.out_busy    = r_out_valid && i_out_stall;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_h[H_W-2:0];
        mem_wdata = r_cpu_head;
        mem_re    = 1'b0;
        mem_raddr = r_cpu_head[H_W-2:0];
        case (i_cmd)
            C_THREAD: begin
                mem_we    = 1'b1;
                mem_waddr = {ix, r_cnt[SLOT_W-1:0]};
                mem_wdata = o_st.thread_last ? HNIL
                          : {1'b0, ix, r_cnt[SLOT_W-1:0] + SLOT_W'(1)};
            end
            C_BATCH_WR, C_PUSH: begin
                mem_we = 1'b1;
            end
            C_FL_WR, C_FREE_LINK: begin
                mem_we    = 1'b1;
                mem_wdata = fh;
            end
            C_RD_CPU, C_FL_RD: begin
                mem_re = 1'b1;
            end
            C_BATCH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = fh[H_W-2:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_link[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_EMIT) begin
            r_out.status        <= r_stat;
            r_out.handle_out    <= r_hout;
            r_out.partial_pages <= r_ptotal;
            r_out.slabs_used    <= r_stotal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == C_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= OBJ_RST;
            r_cpu_head <= HNIL;
            r_cpu_cnt  <= '0;
            r_cpu_page <= PNIL;
            r_phead    <= PNIL;
            r_ptotal   <= '0;
            r_stotal   <= '0;
            r_slab     <= '0;
            r_onp      <= '0;
            for (int p = 0; p < NUM_PAGES; p++) begin
                r_fhead[p] <= HNIL;
                r_inuse[p] <= '0;
                r_objs[p]  <= '0;
                r_pprev[p] <= PNIL;
                r_pnext[p] <= PNIL;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            case (i_cmd)
                C_ACCEPT: begin
                    r_op   <= i_req.op;
                    r_h    <= {1'b0, i_req.object_handle};
                    r_pg   <= {1'b0, i_req.object_handle[11:SLOT_W]};
                    r_stat <= ST_OK;
                    r_hout <= '0;
                end
                C_RD_CPU, C_FL_RD: begin
                    r_h <= r_cpu_head;
                end
                C_POP: begin
                    r_cpu_head <= r_rdata;
                    if (r_cpu_cnt != '0) begin
                        r_cpu_cnt <= r_cpu_cnt - CNT_W'(1);
                    end
                    r_pg   <= {1'b0, r_h[H_W-2:SLOT_W]};
                    r_hout <= r_h[11:0];
                end
                C_INC: begin
                    r_inuse[ix] <= inu + OBJ_W'(1);
                    if (o_st.inc_full && (r_pg == r_cpu_page) && (r_cpu_head == HNIL)
                        && (fh == HNIL)) begin
                        r_cpu_page <= PNIL;
                    end
                end
                C_LD_CPU_PAGE: begin
                    r_pg <= r_cpu_page;
                end
                C_ACQ: begin
                    r_cnt <= '0;
                    if (!r_pg[PG_W] && (fh == HNIL) && (r_cpu_head == HNIL) && (inu == obj)) begin
                        r_cpu_page <= PNIL;
                    end
                end
                C_TAKE_PART: begin
                    r_pg       <= r_phead;
                    r_cpu_page <= r_phead;
                end
                C_PREMOVE: begin
                    if (onp) begin
                        if (!pr[PG_W]) begin
                            r_pnext[pr[PG_W-1:0]] <= nx;
                        end else begin
                            r_phead <= nx;
                        end
                        if (!nx[PG_W]) begin
                            r_pprev[nx[PG_W-1:0]] <= pr;
                        end
                        r_pprev[ix] <= PNIL;
                        r_pnext[ix] <= PNIL;
                        r_onp[ix]   <= 1'b0;
                        if (r_ptotal != '0) begin
                            r_ptotal <= r_ptotal - CNT5_W'(1);
                        end
                    end
                end
                C_PADD: begin
                    if (!onp) begin
                        r_pprev[ix] <= PNIL;
                        r_pnext[ix] <= r_phead;
                        if (!r_phead[PG_W]) begin
                            r_pprev[r_phead[PG_W-1:0]] <= r_pg;
                        end
                        r_phead   <= r_pg;
                        r_onp[ix] <= 1'b1;
                        r_ptotal  <= r_ptotal + CNT5_W'(1);
                    end
                end
                C_NEW_SLAB: begin
                    r_pg             <= {1'b0, free_pg};
                    r_cnt            <= '0;
                    r_n              <= n_clamp;
                    r_fhead[free_pg] <= {1'b0, free_pg, SLOT_W'(0)};
                    r_inuse[free_pg] <= '0;
                    r_objs[free_pg]  <= n_clamp;
                    r_slab[free_pg]  <= 1'b1;
                    r_onp[free_pg]   <= 1'b0;
                    r_pprev[free_pg] <= PNIL;
                    r_pnext[free_pg] <= PNIL;
                    r_stotal         <= r_stotal + CNT5_W'(1);
                    r_cpu_page       <= {1'b0, free_pg};
                end
                C_THREAD: begin
                    r_cnt <= o_st.thread_last ? '0 : r_cnt + OBJ_W'(1);
                end
                C_BATCH_RD: begin
                    r_h <= fh;
                end
                C_BATCH_WR: begin
                    r_fhead[ix] <= r_rdata;
                    r_cpu_head  <= r_h;
                    r_cpu_cnt   <= r_cpu_cnt + CNT_W'(1);
                    r_cnt       <= r_cnt + OBJ_W'(1);
                end
                C_DEC: begin
                    r_inuse[ix] <= inu - OBJ_W'(1);
                    r_zero      <= (inu == OBJ_W'(1));
                end
                C_PUSH: begin
                    r_cpu_head <= r_h;
                    r_cpu_cnt  <= r_cpu_cnt + CNT_W'(1);
                end
                C_FL_POP: begin
                    r_cpu_head <= r_rdata;
                    if (r_cpu_cnt != '0) begin
                        r_cpu_cnt <= r_cpu_cnt - CNT_W'(1);
                    end
                    r_pg <= {1'b0, r_h[H_W-2:SLOT_W]};
                end
                C_FL_WR, C_FREE_LINK: begin
                    r_fhead[ix] <= r_h;
                end
                C_CPU_CHK: begin
                    if (r_zero && (r_cpu_cnt == '0)) begin
                        r_cpu_page <= PNIL;
                    end
                end
                C_RELEASE: begin
                    r_slab[ix]  <= 1'b0;
                    r_fhead[ix] <= HNIL;
                    r_objs[ix]  <= '0;
                    if (r_stotal != '0) begin
                        r_stotal <= r_stotal - CNT5_W'(1);
                    end
                end
                C_SET_OOM: begin
                    r_stat <= ST_OOM;
                end
                C_SET_BAD: begin
                    r_stat <= ST_BAD;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_ptotal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptotal == CNT5_W'($countones(r_onp)))
        else $error("partial page count disagrees with partial flags");

    a_stotal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stotal == CNT5_W'($countones(r_slab)))
        else $error("slab count disagrees with slab flags");

    a_thread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == C_THREAD |-> r_cnt < r_n)
        else $error("threading ran past the slab size");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == C_EMIT |=> r_out_valid)
        else $error("result was not presented after emit");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import soa_pkg::*;

    localparam int HANDLE_END = NUM_PAGES * MAX_SLOTS;
    localparam int PAGE_END   = NUM_PAGES;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_req             i_in        = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [OBJ_W-1:0] i_cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_rsp             o_out;

    slab_object_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the allocator state.
    int unsigned slab_size_reg;
    int unsigned link_mem [HANDLE_END];
    int unsigned pg_free_head [PAGE_END];
    int unsigned pg_inuse [PAGE_END];
    int unsigned pg_slots [PAGE_END];
    bit          pg_is_slab [PAGE_END];
    bit          pg_on_partial [PAGE_END];
    int unsigned part_prev [PAGE_END];
    int unsigned part_next [PAGE_END];
    int unsigned part_head;
    int unsigned part_count;
    int unsigned cpu_head;
    int unsigned cpu_count;
    int unsigned cpu_pg;
    int unsigned slab_count;

    t_rsp        pending_rsp[$];
    int unsigned live_handles[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_start    = 0;
    int          hold_left     = 0;
    int          mismatches    = 0;
    int          checked       = 0;
    int          n_alloc       = 0;
    int          n_free        = 0;
    int          n_oom         = 0;
    int          n_bad         = 0;

    function automatic int unsigned read_link(int unsigned h);
        return (h < HANDLE_END) ? link_mem[h] : HANDLE_END;
    endfunction

    function automatic void write_link(int unsigned h, int unsigned v);
        if (h < HANDLE_END) link_mem[h] = v;
    endfunction

    function automatic void partial_link(int unsigned p);
        if (p >= PAGE_END || pg_on_partial[p]) return;
        part_prev[p] = PAGE_END;
        part_next[p] = part_head;
        if (part_head < PAGE_END) part_prev[part_head] = p;
        part_head = p;
        pg_on_partial[p] = 1;
        part_count++;
    endfunction

    function automatic void partial_unlink(int unsigned p);
        int unsigned pr;
        int unsigned nx;
        if (p >= PAGE_END || !pg_on_partial[p]) return;
        pr = part_prev[p];
        nx = part_next[p];
        if (pr < PAGE_END) part_next[pr] = nx;
        else part_head = nx;
        if (nx < PAGE_END) part_prev[nx] = pr;
        part_prev[p] = PAGE_END;
        part_next[p] = PAGE_END;
        pg_on_partial[p] = 0;
        if (part_count > 0) part_count--;
    endfunction

    function automatic void stack_push(int unsigned h);
        write_link(h, cpu_head);
        cpu_head = h;
        cpu_count++;
    endfunction

    function automatic int unsigned stack_pop();
        int unsigned h;
        h = cpu_head;
        cpu_head = read_link(h);
        if (cpu_count > 0) cpu_count--;
        return h;
    endfunction

    function automatic int unsigned thread_slab();
        int unsigned p;
        int unsigned n;
        int unsigned base;
        p = 0;
        while (p < PAGE_END && pg_is_slab[p]) p++;
        if (p >= PAGE_END) return PAGE_END;
        n = slab_size_reg;
        if (n == 0) n = 1;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        base = p * MAX_SLOTS;
        for (int unsigned i = 0; i + 1 < n; i++) link_mem[base + i] = base + i + 1;
        link_mem[base + n - 1] = HANDLE_END;
        pg_free_head[p] = base;
        pg_inuse[p] = 0;
        pg_slots[p] = n;
        pg_is_slab[p] = 1;
        pg_on_partial[p] = 0;
        part_prev[p] = PAGE_END;
        part_next[p] = PAGE_END;
        slab_count++;
        cpu_pg = p;
        return p;
    endfunction

    function automatic int unsigned pick_refill_page();
        int unsigned p;
        p = cpu_pg;
        if (p < PAGE_END && pg_free_head[p] != HANDLE_END) return p;
        if (p < PAGE_END && cpu_head == HANDLE_END && pg_inuse[p] == pg_slots[p])
            cpu_pg = PAGE_END;
        if (part_head < PAGE_END) begin
            p = part_head;
            partial_unlink(p);
            cpu_pg = p;
            return p;
        end
        return thread_slab();
    endfunction

    function automatic bit refill_stack();
        int unsigned p;
        int unsigned h;
        p = pick_refill_page();
        if (p >= PAGE_END) return 0;
        for (int b = 0; b < DEF_CPU_BATCH && pg_free_head[p] != HANDLE_END; b++) begin
            h = pg_free_head[p];
            pg_free_head[p] = read_link(h);
            stack_push(h);
        end
        return cpu_head != HANDLE_END;
    endfunction

    function automatic void flush_stack();
        int unsigned h;
        int unsigned p;
        while (cpu_head != HANDLE_END && cpu_count > DEF_CPU_LIMIT) begin
            h = stack_pop();
            p = h / MAX_SLOTS;
            if (p >= PAGE_END) continue;
            write_link(h, pg_free_head[p]);
            pg_free_head[p] = h;
            if (p != cpu_pg && pg_inuse[p] < pg_slots[p]) partial_link(p);
        end
    endfunction

    function automatic void reset_allocator_model();
        slab_size_reg = MAX_SLOTS;
        foreach (link_mem[i]) link_mem[i] = 0;
        for (int p = 0; p < PAGE_END; p++) begin
            pg_free_head[p] = HANDLE_END;
            pg_inuse[p] = 0;
            pg_slots[p] = 0;
            pg_is_slab[p] = 0;
            pg_on_partial[p] = 0;
            part_prev[p] = PAGE_END;
            part_next[p] = PAGE_END;
        end
        part_head = PAGE_END;
        part_count = 0;
        cpu_head = HANDLE_END;
        cpu_count = 0;
        cpu_pg = PAGE_END;
        slab_count = 0;
    endfunction

    function automatic t_rsp predict_allocator(t_req r);
        t_rsp        res;
        int unsigned h;
        int unsigned p;
        res = '0;
        res.status = ST_OK;
        if (r.op == OP_ALLOC) begin
            if (cpu_head == HANDLE_END && !refill_stack()) begin
                res.status = ST_OOM;
            end else begin
                h = stack_pop();
                p = h / MAX_SLOTS;
                res.handle_out = h[11:0];
                if (p < PAGE_END) begin
                    pg_inuse[p]++;
                    if (pg_inuse[p] == pg_slots[p]) begin
                        partial_unlink(p);
                        if (p == cpu_pg && cpu_head == HANDLE_END
                            && pg_free_head[p] == HANDLE_END)
                            cpu_pg = PAGE_END;
                    end
                end
            end
        end else begin
            h = r.object_handle;
            p = h / MAX_SLOTS;
            if (p >= PAGE_END || !pg_is_slab[p] || h - p * MAX_SLOTS >= pg_slots[p]
                || pg_inuse[p] == 0) begin
                res.status = ST_BAD;
            end else begin
                pg_inuse[p]--;
                if (p == cpu_pg) begin
                    stack_push(h);
                    flush_stack();
                    if (pg_inuse[p] == 0 && cpu_count == 0) cpu_pg = PAGE_END;
                end else begin
                    write_link(h, pg_free_head[p]);
                    pg_free_head[p] = h;
                    if (pg_inuse[p] == 0) begin
                        partial_unlink(p);
                        pg_is_slab[p] = 0;
                        pg_free_head[p] = HANDLE_END;
                        pg_slots[p] = 0;
                        if (slab_count > 0) slab_count--;
                    end else if (pg_inuse[p] < pg_slots[p]) begin
                        partial_link(p);
                    end
                end
            end
        end
        res.partial_pages = part_count[4:0];
        res.slabs_used    = slab_count[4:0];
        return res;
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start = 0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            checked++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", o_out);
            end else begin
                want = pending_rsp.pop_front();
                if (o_out.status !== want.status || o_out.handle_out !== want.handle_out
                    || o_out.partial_pages !== want.partial_pages
                    || o_out.slabs_used !== want.slabs_used) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, o_out);
                end
            end
        end
    end

    task automatic send_request(t_op op, int unsigned h);
        t_req r;
        t_rsp res;
        r.op = op;
        r.object_handle = h[11:0];
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= r;
        do @(posedge i_clk); while (o_in_stall);
        res = predict_allocator(r);
        pending_rsp.push_back(res);
        if (op == OP_ALLOC) begin
            n_alloc++;
            if (res.status == ST_OK) live_handles.push_back(res.handle_out);
            else n_oom++;
        end else begin
            n_free++;
            if (res.status == ST_BAD) n_bad++;
        end
    endtask

    task automatic free_live(int idx);
        int unsigned h;
        h = live_handles[idx];
        live_handles.delete(idx);
        send_request(OP_FREE, h);
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_slab_size(int unsigned v);
        drain_requests();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[OBJ_W-1:0];
        @(posedge i_clk);
        slab_size_reg = v;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_bad_and_double_free();
        send_request(OP_FREE, 12'hFFF);
        send_request(OP_FREE, 12'h000);
        send_request(OP_ALLOC, 0);
        send_request(OP_ALLOC, 0);
        send_request(OP_ALLOC, 0);
        send_request(OP_FREE, live_handles[1]);
        send_request(OP_FREE, live_handles[1]);
        while (live_handles.size() != 0) free_live(0);
        send_request(OP_FREE, 12'h000);
        drain_requests();
    endtask

    task automatic test_out_of_pages();
        write_slab_size(0);
        repeat (19) send_request(OP_ALLOC, 0);
        send_request(OP_FREE, 12'h0FF);
        while (live_handles.size() != 0) free_live(live_handles.size() - 1);
        write_slab_size(511);
        send_request(OP_ALLOC, 0);
        while (live_handles.size() != 0) free_live(0);
        drain_requests();
    endtask

    task automatic test_random_traffic(int count, int max_live);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 8) send_request(OP_FREE, $urandom_range(4095));
            else if (live_handles.size() == 0 || (sel < 58 && live_handles.size() < max_live))
                send_request(OP_ALLOC, 0);
            else free_live($urandom_range(live_handles.size() - 1));
        end
    endtask

    task automatic test_backpressure();
        hold_start = 1;
        for (int i = 0; i < 40; i++) send_request(OP_ALLOC, 0);
        while (live_handles.size() > 20) free_live($urandom_range(live_handles.size() - 1));
        drain_requests();
    endtask

    initial begin
        reset_allocator_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bad_and_double_free();
        test_out_of_pages();
        send_idle_pct = 11;
        recv_idle_pct = 66;
        write_slab_size(3);
        test_random_traffic(400, 60);
        write_slab_size(1);
        test_random_traffic(150, 24);
        send_idle_pct = 66;
        recv_idle_pct = 11;
        write_slab_size(17);
        test_random_traffic(400, 120);
        write_slab_size(256);
        test_random_traffic(150, 300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_slab_size(5);
        test_backpressure();
        test_random_traffic(400, 80);
        drain_requests();
        $display("Covered %0d allocations (%0d out of pages) and %0d frees (%0d rejected).",
                 n_alloc, n_oom, n_free, n_bad);
        $display("Slab sizes 0, 1, 3, 5, 17, 256 and 511 were used; %0d results checked.",
                 checked);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/soa_pkg.sv
hw/rtl/soa_ctrl.sv
hw/rtl/soa_datapath.sv
hw/rtl/slab_object_allocator.sv
test/tb_top.sv
